>>> rtl/smbs_pkg.sv
// Shared types, constants and the column-to-multiplexer map of the baseline scan block.
package smbs_pkg;

  localparam int COL_BITS    = 6;
  localparam int SAMPLE_W    = 10;
  localparam int LEVEL_W     = 10;
  localparam int CFG_W       = 8;
  localparam int CNT_W       = 8;
  localparam int MUX_ID_W    = 2;
  localparam int MUX_CH_W    = 4;
  localparam int ROW_SLOTS   = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_W-1:0]    SWEEPS_RESET = 8'd20;
  localparam logic [MUX_ID_W-1:0] MUX_NONE     = 2'd3;

  typedef struct packed {
    logic [MUX_ID_W-1:0] id;
    logic [MUX_CH_W-1:0] ch;
  } mux_sel_t;

  // one classified column item as it sits in the queue
  typedef struct packed {
    logic                               col_ok;
    logic [COL_BITS-1:0]                column;
    logic                               sweep_end;
    mux_sel_t                           mux;
    logic [ROW_SLOTS-1:0][SAMPLE_W-1:0] sample;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV_RD,
    ST_DIV_LOAD,
    ST_DIV_STEP,
    ST_DIV_WR
  } back_st_t;

  // 1-based column ranges: 1-9, 10-13, 14-27 and 28-43, channels count down
  function automatic mux_sel_t map_column(input logic [COL_BITS-1:0] col);
    logic [COL_BITS:0] n;
    mux_sel_t          m;
    n = {1'b0, col} + 7'd1;
    priority if (n <= 7'd9) begin
      m.id = 2'd0;
      m.ch = MUX_CH_W'(7'd16 - n);
    end else if (n <= 7'd13) begin
      m.id = 2'd0;
      m.ch = MUX_CH_W'(7'd13 - n);
    end else if (n <= 7'd27) begin
      m.id = 2'd1;
      m.ch = MUX_CH_W'(7'd29 - n);
    end else if (n <= 7'd43) begin
      m.id = 2'd2;
      m.ch = MUX_CH_W'(7'd43 - n);
    end else begin
      m.id = MUX_NONE;
      m.ch = '0;
    end
    return m;
  endfunction

endpackage

>>> rtl/smbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module smbs_ram #(
  parameter int WIDTH = 54,
  parameter int DEPTH = 36
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/smbs_queue.sv
// Short item queue between the classifying front end and the back end.
module smbs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  smbs_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output smbs_pkg::item_t head
);
  import smbs_pkg::*;

  localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  item_t           entry [QUEUE_DEPTH];
  logic [PTRW-1:0] wr_ptr;
  logic [PTRW-1:0] rd_ptr;
  logic [CNTW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CNTW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign head    = entry[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  function automatic logic [PTRW-1:0] ptr_inc(input logic [PTRW-1:0] p);
    return (p == PTRW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_item;
    end
  end

endmodule

>>> rtl/smbs_front.sv
// Front end: takes input items, checks the column, maps it and masks samples.
module smbs_front #(
  parameter int COLUMNS     = 36,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [smbs_pkg::COL_BITS-1:0]    column,
  input  logic [smbs_pkg::SAMPLE_W-1:0]    sample_row0,
  input  logic [smbs_pkg::SAMPLE_W-1:0]    sample_row1,
  input  logic [smbs_pkg::SAMPLE_W-1:0]    sample_row2,
  input  logic                             q_full,
  output logic                             push,
  output smbs_pkg::item_t                  push_item
);
  import smbs_pkg::*;

  localparam int SW = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] SMASK = SAMPLE_W'((1 << SW) - 1);

  logic col_ok;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;
  assign col_ok   = (column < COL_BITS'(COLUMNS));

  always_comb begin
    push_item.col_ok    = col_ok;
    push_item.column    = column;
    push_item.sweep_end = (column == COL_BITS'(COLUMNS - 1));
    if (col_ok) begin
      push_item.mux = map_column(column);
    end else begin
      push_item.mux.id = MUX_NONE;
      push_item.mux.ch = '0;
    end
    push_item.sample[0] = sample_row0 & SMASK;
    push_item.sample[1] = sample_row1 & SMASK;
    push_item.sample[2] = sample_row2 & SMASK;
  end

endmodule

>>> rtl/smbs_back.sv
// Back end: cell sum store, calibration divide pass, level compute and result register.
module smbs_back #(
  parameter int COLUMNS     = 36,
  parameter int ROWS        = 3,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [smbs_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            q_empty,
  input  smbs_pkg::item_t                 q_head,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [smbs_pkg::MUX_ID_W-1:0]   mux_id,
  output logic [smbs_pkg::MUX_CH_W-1:0]   mux_channel,
  output logic [smbs_pkg::LEVEL_W-1:0]    level_row0,
  output logic [smbs_pkg::LEVEL_W-1:0]    level_row1,
  output logic [smbs_pkg::LEVEL_W-1:0]    level_row2,
  output logic                            calibrating,
  output logic                            sweep_end
);
  import smbs_pkg::*;

  localparam int SUMW  = SAMPLE_BITS + 8;
  localparam int IDXW  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int MEMW  = ROWS * SUMW;
  localparam int STEPW = $clog2(SUMW);

  back_st_t          state;
  back_st_t          state_next;
  item_t             cur;
  logic [COLUMNS-1:0] valid;
  logic [CNT_W-1:0]  sweep_count;
  logic              in_cal;
  logic [CFG_W-1:0]  sweeps_cfg;
  logic [IDXW-1:0]   div_col;
  logic [STEPW-1:0]  step;
  logic [CNT_W-1:0]  rem [ROWS];
  logic [SUMW-1:0]   quo [ROWS];

  logic              ram_re;
  logic              ram_we;
  logic [IDXW-1:0]   ram_raddr;
  logic [IDXW-1:0]   ram_waddr;
  logic [MEMW-1:0]   ram_wdata;
  logic [MEMW-1:0]   ram_rdata;

  logic [IDXW-1:0]   cur_idx;
  logic [IDXW-1:0]   head_idx;
  logic              slot_free;
  logic              load_out;
  logic [CNT_W-1:0]  next_cnt;
  logic [CNT_W-1:0]  need;
  logic              cal_done;
  logic              cal_write;
  logic              rd_valid;
  logic [SUMW-1:0]   base [ROW_SLOTS];
  logic [MEMW-1:0]   sum_word;
  logic [MEMW-1:0]   quo_word;
  logic [LEVEL_W-1:0] level [ROW_SLOTS];
  logic [CNT_W:0]    shifted [ROWS];
  logic              ge [ROWS];

  smbs_ram #(
    .WIDTH (MEMW),
    .DEPTH (COLUMNS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign cur_idx   = cur.column[IDXW-1:0];
  assign head_idx  = q_head.column[IDXW-1:0];
  assign slot_free = !out_valid || out_ready;
  assign next_cnt  = sweep_count + 1'b1;
  assign need      = (sweeps_cfg == '0) ? CNT_W'(1) : sweeps_cfg;
  assign cal_done  = cur.sweep_end && (next_cnt >= need);
  assign cal_write = cur.col_ok && in_cal;
  // a column never written reads as zero
  assign rd_valid  = (state == ST_DIV_LOAD) ? valid[div_col] : valid[cur_idx];

  always_comb begin
    for (int r = 0; r < ROW_SLOTS; r++) begin
      base[r]  = '0;
      level[r] = '0;
    end
    sum_word = '0;
    quo_word = '0;
    for (int r = 0; r < ROWS; r++) begin
      base[r] = rd_valid ? ram_rdata[r*SUMW +: SUMW] : '0;
      sum_word[r*SUMW +: SUMW] = base[r] + SUMW'(cur.sample[r]);
      quo_word[r*SUMW +: SUMW] = quo[r];
      if (cur.col_ok && !in_cal && (SUMW'(cur.sample[r]) > base[r])) begin
        level[r] = LEVEL_W'(SUMW'(cur.sample[r]) - base[r]);
      end
    end
  end

  // one restoring divide step per lane and cycle, divisor is the sweep count
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      shifted[r] = {rem[r], quo[r][SUMW-1]};
      ge[r]      = (shifted[r] >= {1'b0, sweep_count});
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          state_next = (cal_write && cal_done) ? ST_DIV_RD : ST_IDLE;
        end
      end
      ST_DIV_RD:   state_next = ST_DIV_LOAD;
      ST_DIV_LOAD: state_next = ST_DIV_STEP;
      ST_DIV_STEP: begin
        if (step == STEPW'(SUMW - 1)) begin
          state_next = ST_DIV_WR;
        end
      end
      ST_DIV_WR: begin
        state_next = (div_col == IDXW'(COLUMNS - 1)) ? ST_IDLE : ST_DIV_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    load_out  = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = head_idx;
    ram_waddr = cur_idx;
    ram_wdata = sum_word;
    unique case (state)
      ST_IDLE: begin
        q_pop  = !q_empty;
        ram_re = !q_empty && q_head.col_ok;
      end
      ST_EXEC: begin
        load_out = slot_free;
        ram_we   = slot_free && cal_write;
      end
      ST_DIV_RD: begin
        ram_re    = 1'b1;
        ram_raddr = div_col;
      end
      ST_DIV_WR: begin
        ram_we    = 1'b1;
        ram_waddr = div_col;
        ram_wdata = quo_word;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      valid       <= '0;
      sweep_count <= '0;
      in_cal      <= 1'b1;
      sweeps_cfg  <= SWEEPS_RESET;
      div_col     <= '0;
      step        <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        sweeps_cfg <= cfg_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load_out && cal_write) begin
        valid[cur_idx] <= 1'b1;
        if (cur.sweep_end) begin
          sweep_count <= next_cnt;
        end
        if (cal_done) begin
          in_cal <= 1'b0;
        end
      end
      if (state == ST_EXEC) begin
        div_col <= '0;
      end
      if (state == ST_DIV_LOAD) begin
        step <= '0;
      end else if (state == ST_DIV_STEP) begin
        step <= step + 1'b1;
      end
      if (state == ST_DIV_WR) begin
        valid[div_col] <= 1'b1;
        if (div_col != IDXW'(COLUMNS - 1)) begin
          div_col <= div_col + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    for (int r = 0; r < ROWS; r++) begin
      if (state == ST_DIV_LOAD) begin
        rem[r] <= '0;
        quo[r] <= base[r];
      end else if (state == ST_DIV_STEP) begin
        rem[r] <= ge[r] ? CNT_W'(shifted[r] - {1'b0, sweep_count}) : shifted[r][CNT_W-1:0];
        quo[r] <= {quo[r][SUMW-2:0], ge[r]};
      end
    end
    if (load_out) begin
      mux_id      <= cur.mux.id;
      mux_channel <= cur.mux.ch;
      level_row0  <= level[0];
      level_row1  <= level[1];
      level_row2  <= level[2];
      calibrating <= in_cal;
      sweep_end   <= cur.sweep_end;
    end
  end

endmodule

>>> rtl/sensor_matrix_baseline_scan_core.sv
// Top level of the baseline-calibrated sensor matrix scan block.
//
// Input channel (in_valid/in_ready): one column's row samples per item.
// Output channel (out_valid/out_ready): one result per item, in order, with
// the column's multiplexer and channel and the three clamped levels.
// Config channel (cfg_valid/cfg_ready/cfg_data): number of calibration
// sweeps; always ready, write only while the block is idle.
// An accepted item enters a two-entry queue; the back end pops it, reads the
// column's cell word from the store and registers the result once the
// output slot is free. The back end takes no new item until the last one's
// result is registered, set by the store's read then update pair.
// The item that ends the last calibration sweep starts a divide pass over
// the store, one column per pass step (read, load, bit-serial steps, write
// back) with three bit-serial dividers in parallel.
// Items keep queueing until the queue fills, then in_ready drops.
// Reset clears the queue, the per-column valid bits of the store, the sweep
// count, and restarts calibration; no clearing pass over the store.
// When the receiver stalls the result holds; the queue absorbs two items.
module sensor_matrix_baseline_scan_core #(
  parameter int COLUMNS     = 36,
  parameter int ROWS        = 3,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [smbs_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [smbs_pkg::COL_BITS-1:0]   column,
  input  logic [smbs_pkg::SAMPLE_W-1:0]   sample_row0,
  input  logic [smbs_pkg::SAMPLE_W-1:0]   sample_row1,
  input  logic [smbs_pkg::SAMPLE_W-1:0]   sample_row2,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [smbs_pkg::MUX_ID_W-1:0]   mux_id,
  output logic [smbs_pkg::MUX_CH_W-1:0]   mux_channel,
  output logic [smbs_pkg::LEVEL_W-1:0]    level_row0,
  output logic [smbs_pkg::LEVEL_W-1:0]    level_row1,
  output logic [smbs_pkg::LEVEL_W-1:0]    level_row2,
  output logic                            calibrating,
  output logic                            sweep_end
);
  import smbs_pkg::*;

  logic  q_full;
  logic  q_empty;
  logic  push;
  logic  q_pop;
  item_t push_item;
  item_t q_head;

  smbs_front #(
    .COLUMNS     (COLUMNS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .column      (column),
    .sample_row0 (sample_row0),
    .sample_row1 (sample_row1),
    .sample_row2 (sample_row2),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item)
  );

  smbs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  smbs_back #(
    .COLUMNS     (COLUMNS),
    .ROWS        (ROWS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mux_id      (mux_id),
    .mux_channel (mux_channel),
    .level_row0  (level_row0),
    .level_row1  (level_row1),
    .level_row2  (level_row2),
    .calibrating (calibrating),
    .sweep_end   (sweep_end)
  );

endmodule

>>> rtl/smbs_checker.sv
// Port-level checks for the scan block, bound to its top level.
module smbs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [smbs_pkg::MUX_ID_W-1:0]   mux_id,
  input logic [smbs_pkg::MUX_CH_W-1:0]   mux_channel,
  input logic [smbs_pkg::LEVEL_W-1:0]    level_row0,
  input logic [smbs_pkg::LEVEL_W-1:0]    level_row1,
  input logic [smbs_pkg::LEVEL_W-1:0]    level_row2,
  input logic                            calibrating,
  input logic                            sweep_end
);
  import smbs_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mux_id) && $stable(mux_channel)
      && $stable(level_row0) && $stable(level_row1) && $stable(level_row2)
      && $stable(calibrating) && $stable(sweep_end))
    else $error("result changed while stalled");

  // an out-of-range column carries no channel, level or sweep end
  a_bad_column: assert property (@(posedge clk) disable iff (rst)
    out_valid && (mux_id == MUX_NONE) |->
      (mux_channel == '0) && !sweep_end
      && (level_row0 == '0) && (level_row1 == '0) && (level_row2 == '0))
    else $error("ignored column item carries data");

  // no levels while the baseline is gathered
  a_cal_levels: assert property (@(posedge clk) disable iff (rst)
    out_valid && calibrating |->
      (level_row0 == '0) && (level_row1 == '0) && (level_row2 == '0))
    else $error("level reported during calibration");

  // calibration never restarts without reset
  a_cal_once: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !calibrating |=> !(out_valid && calibrating))
    else $error("calibration resumed after it ended");

endmodule

bind sensor_matrix_baseline_scan_core smbs_checker u_smbs_checker (.*);

>>> sim/testbench.sv
// Self-checking testbench for the baseline-calibrated sensor matrix scan core.
`timescale 1ns / 100ps

module testbench;
  import smbs_pkg::*;

  localparam int SCAN_COLS   = 36;
  localparam int SCAN_ROWS   = 3;
  localparam int NUM_DIRECT  = 15;
  // quiet time before a register write, covers the divide pass over the store
  localparam int DIV_GAP     = SCAN_COLS * (SAMPLE_W + 11) + 32;
  localparam int HOLD_CYCLES = 100;

  typedef struct packed {
    logic [MUX_ID_W-1:0]               id;
    logic [MUX_CH_W-1:0]               ch;
    logic [SCAN_ROWS-1:0][LEVEL_W-1:0] level;
    logic                              cal;
    logic                              send;
  } scan_result_t;

  typedef struct packed {
    logic                typed;
    logic [COL_BITS-1:0] col;
    logic [SAMPLE_W-1:0] s0, s1, s2;
    logic [MUX_ID_W-1:0] id;
    logic [MUX_CH_W-1:0] ch;
    logic                cal;
    logic                send;
  } column_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [COL_BITS-1:0] column = '0;
  logic [SAMPLE_W-1:0] sample_row0 = '0;
  logic [SAMPLE_W-1:0] sample_row1 = '0;
  logic [SAMPLE_W-1:0] sample_row2 = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [MUX_ID_W-1:0] mux_id;
  logic [MUX_CH_W-1:0] mux_channel;
  logic [LEVEL_W-1:0]  level_row0;
  logic [LEVEL_W-1:0]  level_row1;
  logic [LEVEL_W-1:0]  level_row2;
  logic                calibrating;
  logic                sweep_end;

  // predicted block state
  int               cell_sum [SCAN_ROWS][SCAN_COLS];
  logic [CNT_W-1:0] sweeps_done = '0;
  logic             calib_active = 1'b1;
  logic [CFG_W-1:0] sweeps_cfg = SWEEPS_RESET;

  scan_result_t scan_results_due [$];

  int errors          = 0;
  int items_sent      = 0;
  int results_seen    = 0;
  int levels_clamped  = 0;
  int sweeps_averaged = 0;
  int tx_idle_pct     = 20;
  int rx_idle_pct     = 78;
  int next_col        = 0;
  bit hold_done       = 1'b0;

  sensor_matrix_baseline_scan_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .column      (column),
    .sample_row0 (sample_row0),
    .sample_row1 (sample_row1),
    .sample_row2 (sample_row2),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mux_id      (mux_id),
    .mux_channel (mux_channel),
    .level_row0  (level_row0),
    .level_row1  (level_row1),
    .level_row2  (level_row2),
    .calibrating (calibrating),
    .sweep_end   (sweep_end)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic scan_result_t predict_scan(input logic [COL_BITS-1:0] col,
                                                input logic [SCAN_ROWS-1:0][SAMPLE_W-1:0] smp);
    scan_result_t res;
    int           n;
    int           need;
    int           s;
    res = '0;
    if (col >= SCAN_COLS) begin
      res.id  = MUX_NONE;
      res.cal = calib_active;
      return res;
    end
    // 1-based column ranges, channels counting down
    n = int'(col) + 1;
    if (n <= 9) begin
      res.id = 2'd0;
      res.ch = MUX_CH_W'(16 - n);
    end else if (n <= 13) begin
      res.id = 2'd0;
      res.ch = MUX_CH_W'(13 - n);
    end else if (n <= 27) begin
      res.id = 2'd1;
      res.ch = MUX_CH_W'(29 - n);
    end else begin
      res.id = 2'd2;
      res.ch = MUX_CH_W'(43 - n);
    end
    res.send = (col == SCAN_COLS - 1);
    if (calib_active) begin
      res.cal = 1'b1;
      for (int row = 0; row < SCAN_ROWS; row++)
        cell_sum[row][col] += int'(smp[row]);
      if (res.send) begin
        need = (sweeps_cfg == 0) ? 1 : int'(sweeps_cfg);
        sweeps_done = sweeps_done + 1'b1;
        if (int'(sweeps_done) >= need) begin
          for (int row = 0; row < SCAN_ROWS; row++)
            for (int c = 0; c < SCAN_COLS; c++)
              cell_sum[row][c] = cell_sum[row][c] / int'(sweeps_done);
          calib_active    = 1'b0;
          sweeps_averaged = int'(sweeps_done);
        end
      end
    end else begin
      for (int row = 0; row < SCAN_ROWS; row++) begin
        s = int'(smp[row]);
        if (s > cell_sum[row][col]) begin
          res.level[row] = LEVEL_W'(s - cell_sum[row][col]);
        end else begin
          levels_clamped++;
        end
      end
    end
    return res;
  endfunction

  // unloaded cells read low during calibration, pressed cells span full scale
  function automatic logic [SAMPLE_W-1:0] pick_sample(input bit quiet);
    int roll;
    roll = $urandom_range(99);
    if (quiet) begin
      if (roll < 35) return '0;
      if (roll < 85) return SAMPLE_W'($urandom_range(120));
      return SAMPLE_W'($urandom);
    end
    if (roll < 12) return '1;
    if (roll < 20) return '0;
    return SAMPLE_W'($urandom);
  endfunction

  task automatic offer_column(input logic [COL_BITS-1:0] col,
                              input logic [SCAN_ROWS-1:0][SAMPLE_W-1:0] smp,
                              input bit typed, input scan_result_t typed_res);
    scan_result_t res;
    if (items_sent < 240) begin
      tx_idle_pct = 20;
      rx_idle_pct = 78;
    end else if (items_sent < 480) begin
      tx_idle_pct = 78;
      rx_idle_pct = 20;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    column      <= col;
    sample_row0 <= smp[0];
    sample_row1 <= smp[1];
    sample_row2 <= smp[2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = predict_scan(col, smp);
    scan_results_due.push_back(typed ? typed_res : res);
    items_sent++;
    @(negedge clk);
  endtask

  // mostly in-order sweeps, with stray columns and out-of-range columns mixed in
  task automatic run_scans(input int count, input bit to_calibrated);
    logic [COL_BITS-1:0]                col;
    logic [SCAN_ROWS-1:0][SAMPLE_W-1:0] smp;
    int                                 roll;
    int                                 k;
    k = 0;
    while (to_calibrated ? calib_active : (k < count)) begin
      roll = $urandom_range(99);
      if (roll < 6) begin
        col = COL_BITS'($urandom_range(63, SCAN_COLS));
      end else if (roll < 16) begin
        col = COL_BITS'($urandom_range(SCAN_COLS - 1));
      end else begin
        col      = COL_BITS'(next_col);
        next_col = (next_col + 1) % SCAN_COLS;
      end
      for (int row = 0; row < SCAN_ROWS; row++)
        smp[row] = pick_sample(calib_active);
      offer_column(col, smp, 1'b0, '0);
      k++;
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (scan_results_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_sweeps(input logic [CFG_W-1:0] value);
    drain_results();
    repeat (DIV_GAP) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sweeps_cfg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    scan_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (scan_results_due.size() == 0) begin
        $error("result with none due: mux_id %0d mux_channel %0d", mux_id, mux_channel);
        errors++;
      end else begin
        want = scan_results_due.pop_front();
        check_field("mux_id", 32'(want.id), 32'(mux_id));
        check_field("mux_channel", 32'(want.ch), 32'(mux_channel));
        check_field("level_row0", 32'(want.level[0]), 32'(level_row0));
        check_field("level_row1", 32'(want.level[1]), 32'(level_row1));
        check_field("level_row2", 32'(want.level[2]), 32'(level_row2));
        check_field("calibrating", 32'(want.cal), 32'(calibrating));
        check_field("sweep_end", 32'(want.send), 32'(sweep_end));
      end
    end
  end

  // receiver; one long hold-off lets the queue fill and back up the input
  initial begin
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= 150) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    column_row_t  dir_rows [NUM_DIRECT];
    scan_result_t typed_res;
    logic [SCAN_ROWS-1:0][SAMPLE_W-1:0] smp;
    for (int row = 0; row < SCAN_ROWS; row++)
      for (int c = 0; c < SCAN_COLS; c++)
        cell_sum[row][c] = 0;
    // all rows run while calibrating: levels zero, map read off the column ranges
    dir_rows = '{
      '{1'b1, 6'd0,  10'd1023,  10'd1023,  10'd1023,  2'd0, 4'd15, 1'b1, 1'b0},
      '{1'b1, 6'd0,  10'd0,     10'd0,     10'd0,     2'd0, 4'd15, 1'b1, 1'b0},
      '{1'b1, 6'd8,  10'h2AA,   10'h155,   10'd0,     2'd0, 4'd7,  1'b1, 1'b0},
      '{1'b1, 6'd9,  10'h155,   10'h2AA,   10'd1023,  2'd0, 4'd3,  1'b1, 1'b0},
      '{1'b1, 6'd12, 10'd1,     10'd512,   10'd1022,  2'd0, 4'd0,  1'b1, 1'b0},
      '{1'b1, 6'd13, 10'd1023,  10'd0,     10'd1023,  2'd1, 4'd15, 1'b1, 1'b0},
      '{1'b1, 6'd17, 10'd0,     10'd1023,  10'd0,     2'd1, 4'd11, 1'b1, 1'b0},
      '{1'b1, 6'd21, 10'h155,   10'h155,   10'h155,   2'd1, 4'd7,  1'b1, 1'b0},
      '{1'b1, 6'd26, 10'h2AA,   10'h2AA,   10'h2AA,   2'd1, 4'd2,  1'b1, 1'b0},
      '{1'b1, 6'd27, 10'd1023,  10'd1023,  10'd0,     2'd2, 4'd15, 1'b1, 1'b0},
      '{1'b1, 6'd34, 10'd0,     10'd0,     10'd1023,  2'd2, 4'd8,  1'b1, 1'b0},
      '{1'b1, 6'd35, 10'd1023,  10'd1023,  10'd1023,  2'd2, 4'd7,  1'b1, 1'b1},
      '{1'b1, 6'd36, 10'd1023,  10'd1023,  10'd1023,  MUX_NONE, 4'd0, 1'b1, 1'b0},
      '{1'b1, 6'd42, 10'h2AA,   10'h155,   10'h2AA,   MUX_NONE, 4'd0, 1'b1, 1'b0},
      '{1'b1, 6'd63, 10'd1023,  10'd1023,  10'd1023,  MUX_NONE, 4'd0, 1'b1, 1'b0}
    };
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_sweeps(8'd255);
    foreach (dir_rows[i]) begin
      typed_res      = '0;
      typed_res.id   = dir_rows[i].id;
      typed_res.ch   = dir_rows[i].ch;
      typed_res.cal  = dir_rows[i].cal;
      typed_res.send = dir_rows[i].send;
      smp = {dir_rows[i].s2, dir_rows[i].s1, dir_rows[i].s0};
      offer_column(dir_rows[i].col, smp, dir_rows[i].typed, typed_res);
    end

    write_sweeps(8'd3);
    run_scans(40, 1'b0);
    // zero counts as one, below the sweeps already summed: ends at next sweep end
    write_sweeps('0);
    run_scans(0, 1'b1);
    // writes after calibration must not disturb the baselines
    write_sweeps(8'd1);
    run_scans(100, 1'b0);
    drain_results();
    run_scans(110, 1'b0);
    write_sweeps(8'd255);
    run_scans(210, 1'b0);
    write_sweeps(SWEEPS_RESET);
    run_scans(200, 1'b0);

    drain_results();
    repeat (40) @(negedge clk);
    $display("run: %0d items (%0d directed), %0d results checked",
             items_sent, NUM_DIRECT, results_seen);
    $display("run: baselines averaged over %0d sweeps, %0d levels clamped at zero",
             sweeps_averaged, levels_clamped);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("testbench: errors");
    $finish;
  end

endmodule

>>> sensor_matrix_baseline_scan_core.f
rtl/smbs_pkg.sv
rtl/smbs_ram.sv
rtl/smbs_queue.sv
rtl/smbs_front.sv
rtl/smbs_back.sv
rtl/sensor_matrix_baseline_scan_core.sv
rtl/smbs_checker.sv
sim/testbench.sv
